/* src/crcdf_pkg.sv */
// ----------------------------------------------------------------------------
// CRC-16 frame deframer package
// Shared constants, phase encoding, result word layout and the bytewise
// CRC-16/MODBUS update.
// ----------------------------------------------------------------------------
`default_nettype none

package crcdf_pkg;

    // Number of leading data bytes that are emitted as data words.
    localparam int unsigned MAX_DATA = 12;

    // Reflected CRC-16/MODBUS: start value and reversed polynomial.
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Result word kinds.
    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Receive phase, one-hot.
    typedef enum logic [7:0] {
        PH_START_LO = 8'b0000_0001,
        PH_START_HI = 8'b0000_0010,
        PH_TYPE     = 8'b0000_0100,
        PH_LENGTH   = 8'b0000_1000,
        PH_DATA     = 8'b0001_0000,
        PH_CRC_LO   = 8'b0010_0000,
        PH_CRC_HI   = 8'b0100_0000,
        PH_DONE     = 8'b1000_0000
    } t_phase;

    // One output word.
    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [3:0]  data_index;
        logic [15:0] start_word;
        logic [7:0]  msg_type;
        logic [7:0]  data_length;
        logic [15:0] frame_crc;
        logic [15:0] computed_crc;
        logic        crc_ok;
        logic        too_short;
        logic        run_last;
    } t_result;

    // Bytewise reflected CRC update: eight shift-and-xor steps.
    function automatic logic [15:0] crc_update(input logic [15:0] crc,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* src/crc16_frame_deframer.sv */
// A byte's results are registered into the output queue when the byte is accepted.
// Throughput: one byte per cycle; the input is ready whenever the queue has room for
// two more results. A leading data byte that also ends the frame makes two results,
// which leave the four-entry output queue one per cycle while the receiver is ready.
// Reset (synchronous, active low) empties the queue and returns the receiver to
// the start of a frame with the CRC at 0xFFFF and all held header fields at zero.
// ----------------------------------------------------------------------------
// CRC-16 frame deframer
// Parses start word, type, length, data and CRC-16/MODBUS trailer byte by
// byte, emits the leading data bytes and a frame summary at end of frame.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16_frame_deframer
    import crcdf_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Input byte channel
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [7:0]  i_in_byte,
    input  wire         i_end_of_frame,
    // Result channel
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic        o_kind,
    output logic [7:0]  o_data_byte,
    output logic [3:0]  o_data_index,
    output logic [15:0] o_start_word,
    output logic [7:0]  o_msg_type,
    output logic [7:0]  o_data_length,
    output logic [15:0] o_frame_crc,
    output logic [15:0] o_computed_crc,
    output logic        o_crc_ok,
    output logic        o_too_short,
    output logic        o_run_last
);

    // Receiver state.
    t_phase      r_phase, n_phase;
    logic [7:0]  r_payload_count, n_payload_count;
    logic [15:0] r_crc, n_crc;
    logic [15:0] r_start_word, n_start_word;
    logic [7:0]  r_type, n_type;
    logic [7:0]  r_length, n_length;
    logic [15:0] r_frame_crc, n_frame_crc;

    // Output queue.
    t_result     r_fifo [4];
    logic [1:0]  r_wr_ptr, r_rd_ptr;
    logic [2:0]  r_count, n_count;

    logic        accept;
    logic        pop;
    logic        data_emit;
    logic        complete;
    logic [15:0] crc_next;
    t_result     res_data;
    t_result     res_sum;
    logic [1:0]  push_cnt;

    assign accept   = i_in_valid && o_in_ready;
    assign pop      = o_out_valid && i_out_ready;
    assign crc_next = crc_update(r_crc, i_in_byte);

    // Next receiver state for the byte on the input.
    always_comb begin
        n_phase         = r_phase;
        n_payload_count = r_payload_count;
        n_crc           = r_crc;
        n_start_word    = r_start_word;
        n_type          = r_type;
        n_length        = r_length;
        n_frame_crc     = r_frame_crc;
        data_emit       = 1'b0;
        unique case (r_phase)
            PH_START_LO: begin
                n_start_word = {8'h00, i_in_byte};
                n_crc        = crc_next;
                n_phase      = PH_START_HI;
            end
            PH_START_HI: begin
                n_start_word = {i_in_byte, r_start_word[7:0]};
                n_crc        = crc_next;
                n_phase      = PH_TYPE;
            end
            PH_TYPE: begin
                n_type  = i_in_byte;
                n_crc   = crc_next;
                n_phase = PH_LENGTH;
            end
            PH_LENGTH: begin
                n_length        = i_in_byte;
                n_crc           = crc_next;
                n_payload_count = 8'h00;
                n_phase         = (i_in_byte == 8'h00) ? PH_CRC_LO : PH_DATA;
            end
            PH_DATA: begin
                n_crc           = crc_next;
                data_emit       = (r_payload_count < 8'(MAX_DATA));
                n_payload_count = r_payload_count + 8'd1;
                if (n_payload_count == r_length) begin
                    n_phase = PH_CRC_LO;
                end
            end
            PH_CRC_LO: begin
                n_frame_crc = {8'h00, i_in_byte};
                n_phase     = PH_CRC_HI;
            end
            PH_CRC_HI: begin
                n_frame_crc = {i_in_byte, r_frame_crc[7:0]};
                n_phase     = PH_DONE;
            end
            PH_DONE: begin
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = PH_START_LO;
            end
        endcase
    end

    // Result words built from the updated state.
    assign complete = (n_phase == PH_DONE);

    always_comb begin
        res_data            = '0;
        res_data.kind       = KIND_DATA;
        res_data.data_byte  = i_in_byte;
        res_data.data_index = r_payload_count[3:0];
        res_data.run_last   = !i_end_of_frame;

        res_sum              = '0;
        res_sum.kind         = KIND_SUMMARY;
        res_sum.start_word   = n_start_word;
        res_sum.msg_type     = n_type;
        res_sum.data_length  = n_length;
        res_sum.frame_crc    = n_frame_crc;
        res_sum.computed_crc = n_crc;
        res_sum.crc_ok       = complete && (n_crc == n_frame_crc);
        res_sum.too_short    = !complete;
        res_sum.run_last     = 1'b1;
    end

    // The receiver state advances on every accepted byte and restarts after end of frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_START_LO;
            r_payload_count <= 8'h00;
            r_crc           <= CRC_INIT;
            r_start_word    <= 16'h0000;
            r_type          <= 8'h00;
            r_length        <= 8'h00;
            r_frame_crc     <= 16'h0000;
        end else if (accept) begin
            if (i_end_of_frame) begin
                r_phase         <= PH_START_LO;
                r_payload_count <= 8'h00;
                r_crc           <= CRC_INIT;
                r_start_word    <= 16'h0000;
                r_type          <= 8'h00;
                r_length        <= 8'h00;
                r_frame_crc     <= 16'h0000;
            end else begin
                r_phase         <= n_phase;
                r_payload_count <= n_payload_count;
                r_crc           <= n_crc;
                r_start_word    <= n_start_word;
                r_type          <= n_type;
                r_length        <= n_length;
                r_frame_crc     <= n_frame_crc;
            end
        end
    end

    // Output queue: up to two words pushed per byte, one word popped per cycle while the output is ready.
    always_comb begin
        push_cnt = 2'd0;
        if (accept) begin
            push_cnt = {1'b0, data_emit} + {1'b0, i_end_of_frame};
        end
        n_count = r_count + {1'b0, push_cnt} - {2'b00, pop};
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (data_emit) begin
                r_fifo[r_wr_ptr] <= res_data;
                if (i_end_of_frame) begin
                    r_fifo[r_wr_ptr + 2'd1] <= res_sum;
                end
            end else if (i_end_of_frame) begin
                r_fifo[r_wr_ptr] <= res_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            r_wr_ptr <= r_wr_ptr + push_cnt;
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            r_count <= n_count;
        end
    end

    // Room for two words is needed before a byte is taken.
    assign o_in_ready  = (r_count <= 3'd2);
    assign o_out_valid = (r_count != 3'd0);

    assign o_kind         = r_fifo[r_rd_ptr].kind;
    assign o_data_byte    = r_fifo[r_rd_ptr].data_byte;
    assign o_data_index   = r_fifo[r_rd_ptr].data_index;
    assign o_start_word   = r_fifo[r_rd_ptr].start_word;
    assign o_msg_type     = r_fifo[r_rd_ptr].msg_type;
    assign o_data_length  = r_fifo[r_rd_ptr].data_length;
    assign o_frame_crc    = r_fifo[r_rd_ptr].frame_crc;
    assign o_computed_crc = r_fifo[r_rd_ptr].computed_crc;
    assign o_crc_ok       = r_fifo[r_rd_ptr].crc_ok;
    assign o_too_short    = r_fifo[r_rd_ptr].too_short;
    assign o_run_last     = r_fifo[r_rd_ptr].run_last;

endmodule

`default_nettype wire

/* src/crcdf_checker.sv */
// ----------------------------------------------------------------------------
// CRC-16 frame deframer port checker
// Watches the top-level ports and flags protocol and result-format errors.
// ----------------------------------------------------------------------------
`default_nettype none

module crcdf_checker
    import crcdf_pkg::*;
(
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        o_in_ready,
    input wire [7:0]  i_in_byte,
    input wire        i_end_of_frame,
    input wire        o_out_valid,
    input wire        i_out_ready,
    input wire        o_kind,
    input wire [7:0]  o_data_byte,
    input wire [3:0]  o_data_index,
    input wire [15:0] o_start_word,
    input wire [7:0]  o_msg_type,
    input wire [7:0]  o_data_length,
    input wire [15:0] o_frame_crc,
    input wire [15:0] o_computed_crc,
    input wire        o_crc_ok,
    input wire        o_too_short,
    input wire        o_run_last
);

    // A stalled result word stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result word withdrawn while stalled");

    // A frame that ended early never reports a CRC match.
    a_short_no_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_SUMMARY && o_too_short |-> !o_crc_ok)
        else $error("too-short frame flagged with good CRC");

    // A data word carries an index within the emitted range and clear summary fields.
    a_data_fmt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_DATA |->
            (o_data_index < 4'(MAX_DATA)) && o_start_word == 16'h0000 &&
            o_computed_crc == 16'h0000 && !o_crc_ok && !o_too_short)
        else $error("malformed data word");

    // A summary always closes the results of its byte.
    a_sum_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_SUMMARY |->
            o_run_last && o_data_byte == 8'h00 && o_data_index == 4'h0)
        else $error("malformed summary word");

endmodule

bind crc16_frame_deframer crcdf_checker u_crcdf_checker (.*);

`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CRC-16 frame deframer testbench
// Feeds framed byte streams (well-formed, corrupted, cut short, with trailing
// bytes, and short bursts of noise) through the deframer. Every accepted byte
// is run through a local model of the receiver. The model's data and summary
// words are queued, and each word that leaves the block is checked against
// them field by field. Sender idling and receiver stalls vary by phase.
// ----------------------------------------------------------------------------

module tb;
    import crcdf_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int BYTES_PER_PART = 475;

    typedef struct packed {
        logic [7:0] value;
        logic       eof;
    } t_rx_byte;

    typedef enum int {
        FRM_GOOD,
        FRM_BAD_CRC,
        FRM_CUT,
        FRM_TRAILING
    } t_frame_style;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_in_byte = 8'h00;
    logic        i_end_of_frame = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_kind;
    logic [7:0]  o_data_byte;
    logic [3:0]  o_data_index;
    logic [15:0] o_start_word;
    logic [7:0]  o_msg_type;
    logic [7:0]  o_data_length;
    logic [15:0] o_frame_crc;
    logic [15:0] o_computed_crc;
    logic        o_crc_ok;
    logic        o_too_short;
    logic        o_run_last;

    // Bytes waiting to be sent and words the receiver model says are due.
    t_rx_byte byte_backlog[$];
    t_result  frame_words_due[$];

    // Receiver model state.
    t_phase      rx_phase;
    logic [7:0]  rx_count;
    logic [15:0] rx_crc;
    logic [15:0] rx_start;
    logic [7:0]  rx_type;
    logic [7:0]  rx_len;
    logic [15:0] rx_fcrc;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int bytes_queued   = 0;
    int bytes_accepted = 0;
    int words_checked  = 0;
    int summaries_seen = 0;
    int good_crc_seen  = 0;
    int short_seen     = 0;
    int mismatches     = 0;
    int cycle_count    = 0;

    crc16_frame_deframer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_byte      (i_in_byte),
        .i_end_of_frame (i_end_of_frame),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_data_byte    (o_data_byte),
        .o_data_index   (o_data_index),
        .o_start_word   (o_start_word),
        .o_msg_type     (o_msg_type),
        .o_data_length  (o_data_length),
        .o_frame_crc    (o_frame_crc),
        .o_computed_crc (o_computed_crc),
        .o_crc_ok       (o_crc_ok),
        .o_too_short    (o_too_short),
        .o_run_last     (o_run_last)
    );

    // Clock.
    always #6 i_clk = ~i_clk;

    // Cycle counter for the watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Serial form of the reflected CRC: one data bit folded in per shift.
    function automatic logic [15:0] modbus_crc_step(input logic [15:0] acc,
                                                    input logic [7:0]  b);
        logic [15:0] c;
        logic        fb;
        c = acc;
        for (int k = 0; k < 8; k++) begin
            fb = c[0] ^ b[k];
            c  = c >> 1;
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    // Return the receiver model to the start of a frame.
    function automatic void clear_deframer();
        rx_phase = PH_START_LO;
        rx_count = 8'd0;
        rx_crc   = CRC_INIT;
        rx_start = 16'd0;
        rx_type  = 8'd0;
        rx_len   = 8'd0;
        rx_fcrc  = 16'd0;
    endfunction

    // Advance the receiver model by one byte and queue the words it produces.
    function automatic void deframe_byte(input logic [7:0] b, input logic eof);
        t_result dw;
        t_result sw;
        logic    got_data;
        logic    complete;
        dw       = '0;
        sw       = '0;
        got_data = 1'b0;
        unique case (rx_phase)
            PH_START_LO: begin
                rx_start = {8'h00, b};
                rx_crc   = modbus_crc_step(rx_crc, b);
                rx_phase = PH_START_HI;
            end
            PH_START_HI: begin
                rx_start[15:8] = b;
                rx_crc         = modbus_crc_step(rx_crc, b);
                rx_phase       = PH_TYPE;
            end
            PH_TYPE: begin
                rx_type  = b;
                rx_crc   = modbus_crc_step(rx_crc, b);
                rx_phase = PH_LENGTH;
            end
            PH_LENGTH: begin
                rx_len   = b;
                rx_crc   = modbus_crc_step(rx_crc, b);
                rx_count = 8'd0;
                rx_phase = (b == 8'd0) ? PH_CRC_LO : PH_DATA;
            end
            PH_DATA: begin
                rx_crc = modbus_crc_step(rx_crc, b);
                // Only the leading data bytes are passed on, all enter the CRC.
                if (rx_count < MAX_DATA) begin
                    dw.kind       = KIND_DATA;
                    dw.data_byte  = b;
                    dw.data_index = rx_count[3:0];
                    got_data      = 1'b1;
                end
                rx_count = rx_count + 8'd1;
                if (rx_count == rx_len) begin
                    rx_phase = PH_CRC_LO;
                end
            end
            PH_CRC_LO: begin
                rx_fcrc  = {8'h00, b};
                rx_phase = PH_CRC_HI;
            end
            PH_CRC_HI: begin
                rx_fcrc[15:8] = b;
                rx_phase      = PH_DONE;
            end
            default: begin
            end
        endcase
        if (got_data) begin
            dw.run_last = !eof;
            frame_words_due.push_back(dw);
        end
        if (eof) begin
            complete        = (rx_phase == PH_DONE);
            sw.kind         = KIND_SUMMARY;
            sw.start_word   = rx_start;
            sw.msg_type     = rx_type;
            sw.data_length  = rx_len;
            sw.frame_crc    = rx_fcrc;
            sw.computed_crc = rx_crc;
            sw.crc_ok       = complete && (rx_crc == rx_fcrc);
            sw.too_short    = !complete;
            sw.run_last     = 1'b1;
            frame_words_due.push_back(sw);
            clear_deframer();
        end
    endfunction

    // Build one frame and add its bytes to the backlog. For a cut frame, extra
    // is the number of bytes kept; with trailing bytes it is their count; zero
    // picks either at random. A negative fill gives random data bytes.
    task automatic queue_frame(input logic [15:0] start, input logic [7:0] mtype,
                               input int len, input t_frame_style style,
                               input int extra, input int fill);
        logic [7:0]  fb[$];
        logic [15:0] crc;
        t_rx_byte    item;
        int          n;
        fb = {start[7:0], start[15:8], mtype, len[7:0]};
        for (int k = 0; k < len; k++) begin
            fb.push_back((fill < 0) ? 8'($urandom_range(255)) : fill[7:0]);
        end
        crc = CRC_INIT;
        foreach (fb[k]) begin
            crc = modbus_crc_step(crc, fb[k]);
        end
        if (style == FRM_BAD_CRC) begin
            crc = crc ^ 16'($urandom_range(65535, 1));
        end
        fb.push_back(crc[7:0]);
        fb.push_back(crc[15:8]);
        if (style == FRM_TRAILING) begin
            n = (extra > 0) ? extra : $urandom_range(5, 1);
            for (int k = 0; k < n; k++) begin
                fb.push_back(8'($urandom_range(255)));
            end
        end
        if (style == FRM_CUT) begin
            n = (extra > 0) ? extra : $urandom_range(fb.size() - 1, 1);
            while (fb.size() > n) begin
                void'(fb.pop_back());
            end
        end
        foreach (fb[k]) begin
            item.value = fb[k];
            item.eof   = (k == fb.size() - 1);
            byte_backlog.push_back(item);
        end
        bytes_queued += fb.size();
    endtask

    // A short run of random bytes with random frame ends, closed by a frame end.
    task automatic queue_noise();
        t_rx_byte item;
        int       n;
        n = $urandom_range(8, 1);
        for (int k = 0; k < n; k++) begin
            item.value = 8'($urandom_range(255));
            item.eof   = (k == n - 1) || ($urandom_range(3) == 0);
            byte_backlog.push_back(item);
        end
        bytes_queued += n;
    endtask

    // Mostly well-formed frames with random content, some corrupt or broken.
    task automatic queue_random_part(input int target);
        int stop_at;
        int pick;
        int sz;
        int len;
        stop_at = bytes_queued + target;
        while (bytes_queued < stop_at) begin
            pick = $urandom_range(99);
            sz   = $urandom_range(99);
            if (sz < 65) begin
                len = $urandom_range(12);
            end else if (sz < 97) begin
                len = $urandom_range(40, 13);
            end else begin
                len = $urandom_range(255, 200);
            end
            if (pick < 58) begin
                queue_frame(16'($urandom_range(65535)), 8'($urandom_range(255)),
                            len, FRM_GOOD, 0, -1);
            end else if (pick < 72) begin
                queue_frame(16'($urandom_range(65535)), 8'($urandom_range(255)),
                            len, FRM_BAD_CRC, 0, -1);
            end else if (pick < 84) begin
                queue_frame(16'($urandom_range(65535)), 8'($urandom_range(255)),
                            len, FRM_CUT, 0, -1);
            end else if (pick < 94) begin
                queue_frame(16'($urandom_range(65535)), 8'($urandom_range(255)),
                            len, FRM_TRAILING, 0, -1);
            end else begin
                queue_noise();
            end
        end
    endtask

    task automatic check_field(input string fname, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, fname, want, got);
        end
    endtask

    // Byte driver: presents the next byte from the backlog and runs the
    // receiver model on each accepted byte.
    always @(posedge i_clk) begin : byte_driver
        t_rx_byte item;
        logic     busy;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            busy = i_in_valid;
            if (i_in_valid && o_in_ready) begin
                deframe_byte(i_in_byte, i_end_of_frame);
                bytes_accepted++;
                busy = 1'b0;
            end
            if (!busy) begin
                if (byte_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    item = byte_backlog.pop_front();
                    i_in_valid     <= 1'b1;
                    i_in_byte      <= item.value;
                    i_end_of_frame <= item.eof;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result side back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result monitor: each accepted word against the oldest one due.
    always @(posedge i_clk) begin : result_monitor
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (frame_words_due.size() == 0) begin
                mismatches++;
                $display("%0t: result word expected none, got kind %0b", $time, o_kind);
            end else begin
                want = frame_words_due.pop_front();
                check_field("kind", want.kind, o_kind);
                check_field("data_byte", want.data_byte, o_data_byte);
                check_field("data_index", want.data_index, o_data_index);
                check_field("start_word", want.start_word, o_start_word);
                check_field("msg_type", want.msg_type, o_msg_type);
                check_field("data_length", want.data_length, o_data_length);
                check_field("frame_crc", want.frame_crc, o_frame_crc);
                check_field("computed_crc", want.computed_crc, o_computed_crc);
                check_field("crc_ok", want.crc_ok, o_crc_ok);
                check_field("too_short", want.too_short, o_too_short);
                check_field("run_last", want.run_last, o_run_last);
            end
            words_checked++;
            if (o_kind == KIND_SUMMARY) begin
                summaries_seen++;
                if (o_crc_ok) begin
                    good_crc_seen++;
                end
                if (o_too_short) begin
                    short_seen++;
                end
            end
        end
    end

    // Watchdog.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
        end
        $display("Run stopped after %0d cycles with %0d words still due",
                 cycle_count, frame_words_due.size());
        $display("TEST FAILED");
        $finish;
    end

    // Stimulus and end of run.
    initial begin
        clear_deframer();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames: zero length with extreme header values, a data
        // field of all ones with a trailing byte, a corrupted CRC over a zero
        // data byte, and frames that end early.
        queue_frame(16'h0000, 8'hFF, 0, FRM_GOOD, 0, -1);
        queue_frame(16'hFFFF, 8'h00, 2, FRM_TRAILING, 1, 8'hFF);
        queue_frame(16'hA55A, 8'h5A, 1, FRM_BAD_CRC, 0, 8'h00);
        queue_frame(16'h1234, 8'h80, 0, FRM_CUT, 1, -1);
        queue_frame(16'h8001, 8'h7F, 0, FRM_CUT, 5, -1);
        queue_frame(16'h00FF, 8'h01, 255, FRM_CUT, 4, -1);

        // Idling phases: none, sender idle, receiver stalling, both.
        for (int part = 0; part < 4; part++) begin
            send_idle_pct  = (part == 1) ? 87 : (part == 3) ? 31 : 0;
            recv_stall_pct = (part == 2) ? 87 : (part == 3) ? 31 : 0;
            queue_random_part(BYTES_PER_PART);
            while (byte_backlog.size() != 0) begin
                @(posedge i_clk);
            end
        end

        while (byte_backlog.size() != 0 || i_in_valid || frame_words_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);

        $display("Sent %0d bytes under four idling phases; %0d result words checked.",
                 bytes_accepted, words_checked);
        $display("Frame summaries: %0d, of which %0d with a matching CRC and %0d cut short.",
                 summaries_seen, good_crc_seen, short_seen);
        if (mismatches == 0 && frame_words_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
